[sv/ntp_pkg.sv]
// Package for the NTC thermal power gate: sizes, register map, table and shared types.
// Used by every module of the block; depends on nothing.
package ntp_pkg;

   // Batch and sample format
   localparam int SAMPLES       = 15;
   localparam int ADC_BITS      = 12;
   localparam int TABLE_ENTRIES = 34;

   localparam int SUM_W   = 16;
   localparam int COUNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int AVG_W   = ADC_BITS;

   // Divide-by-SAMPLES through a reciprocal, one correction step
   localparam int RECIP_SHIFT = SUM_W + 4;
   localparam int RECIP       = (2 ** RECIP_SHIFT) / SAMPLES;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int EST_PROD_W  = SUM_W + RECIP_W;

   // Configuration register widths
   localparam int REF_W     = 13;
   localparam int PULL_MV_W = 13;
   localparam int OHMS_W    = 20;
   localparam int CENTI_W   = 15;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REFERENCE_MV = 3'd0,
      CSR_PULL_MV      = 3'd1,
      CSR_PULL_OHMS    = 3'd2,
      CSR_CHARGE_LIMIT = 3'd3,
      CSR_BOOST_LIMIT  = 3'd4
   } csr_index_type;

   localparam logic [REF_W-1:0]     RESET_REFERENCE_MV = 13'd3000;
   localparam logic [PULL_MV_W-1:0] RESET_PULL_MV      = 13'd3300;
   localparam logic [OHMS_W-1:0]    RESET_PULL_OHMS    = 20'd10000;
   localparam logic [CENTI_W-1:0]   RESET_CHARGE_LIMIT = 15'd4500;
   localparam logic [CENTI_W-1:0]   RESET_BOOST_LIMIT  = 15'd5000;

   typedef struct packed {
      logic [REF_W-1:0]     reference_mv;
      logic [PULL_MV_W-1:0] pull_mv;
      logic [OHMS_W-1:0]    pull_ohms;
      logic [CENTI_W-1:0]   charge_limit;
      logic [CENTI_W-1:0]   boost_limit;
   } cfg_type;

   // Conversion arithmetic widths
   localparam int NUM_W  = REF_W + AVG_W;
   localparam int FULL_W = PULL_MV_W + ADC_BITS;
   localparam int CMP_W  = (NUM_W > FULL_W) ? NUM_W : FULL_W;

   localparam int DIV_NUM_W = OHMS_W + NUM_W;
   localparam int DIV_DEN_W = FULL_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   // Resistance table, whole ohms, 5 degree steps from -40 C
   localparam int RES_W  = 18;
   localparam int IDX_W  = $clog2(TABLE_ENTRIES);

   localparam int T_W         = 16;
   localparam int T_MIN_CENTI = -4000;
   localparam int T_MAX_CENTI = 12500;
   localparam int STEP_CENTI  = 500;
   localparam int STEP_W      = $clog2(STEP_CENTI + 1);
   localparam int FRAC_NUM_W  = RES_W + STEP_W;

   localparam logic [RES_W-1:0] RES_TABLE [TABLE_ENTRIES] = '{
      18'd195652, 18'd148171, 18'd113347, 18'd87559, 18'd68237, 18'd53650,
      18'd42506,  18'd33892,  18'd27219,  18'd22021, 18'd17926, 18'd14674,
      18'd12081,  18'd10000,  18'd8315,   18'd6948,  18'd5834,  18'd4917,
      18'd4161,   18'd3535,   18'd3014,   18'd2586,  18'd2228,  18'd1925,
      18'd1669,   18'd1452,   18'd1268,   18'd1110,  18'd974,   18'd858,
      18'd758,    18'd672,    18'd596,    18'd531
   };

   // Batch queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Shared divider handshake
   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] numer;
      logic [DIV_DEN_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_resp_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_SCALE,
      BK_RATIO,
      BK_START_R,
      BK_WAIT_R,
      BK_RANGE,
      BK_SCAN,
      BK_FRAC,
      BK_START_F,
      BK_WAIT_F,
      BK_SUM,
      BK_EMIT
   } back_state_type;

endpackage

[sv/ntp_front.sv]
// Front end: accumulates ADC samples per batch and forms the batch average.
// Depends on ntp_pkg; feeds ntp_avg_queue.
module ntp_front
   import ntp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [ADC_BITS-1:0] req_sample,
   output logic                q_push,
   output logic [AVG_W-1:0]    q_data,
   input  logic                q_full
);

   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               s1_valid_ff, s1_valid_in;
   logic [SUM_W-1:0]   s1_sum_ff, s1_sum_in;
   logic               s2_valid_ff, s2_valid_in;
   logic [SUM_W-1:0]   s2_sum_ff, s2_sum_in;
   logic [SUM_W-1:0]   est_ff, est_in;

   logic                  accept;
   logic [SUM_W-1:0]      sum_next;
   logic                  last;
   logic [EST_PROD_W-1:0] est_prod;
   logic [SUM_W-1:0]      rem;

   assign req_full = s1_valid_ff || s2_valid_ff;
   assign accept   = req_push && !req_full;
   assign sum_next = sum_ff + SUM_W'(req_sample);
   assign last     = (count_ff == COUNT_W'(SAMPLES - 1));
   assign est_prod = EST_PROD_W'(s1_sum_ff) * EST_PROD_W'(RECIP);
   assign rem      = s2_sum_ff - SUM_W'(est_ff * SUM_W'(SAMPLES));
   assign q_push   = s2_valid_ff && !q_full;
   assign q_data   = AVG_W'(est_ff + ((rem >= SUM_W'(SAMPLES)) ? SUM_W'(1) : SUM_W'(0)));

   always_comb begin
      sum_in      = sum_ff;
      count_in    = count_ff;
      s1_valid_in = s1_valid_ff;
      s1_sum_in   = s1_sum_ff;
      s2_valid_in = s2_valid_ff;
      s2_sum_in   = s2_sum_ff;
      est_in      = est_ff;

      // Accumulate; close the batch on its last sample
      if (accept) begin
         if (last) begin
            sum_in      = '0;
            count_in    = '0;
            s1_valid_in = 1'b1;
            s1_sum_in   = sum_next;
         end else begin
            sum_in   = sum_next;
            count_in = count_ff + COUNT_W'(1);
         end
      end

      // Reciprocal estimate of the average
      if (s1_valid_ff && !s2_valid_ff) begin
         s1_valid_in = 1'b0;
         s2_valid_in = 1'b1;
         s2_sum_in   = s1_sum_ff;
         est_in      = SUM_W'(est_prod >> RECIP_SHIFT);
      end

      // Correct by one and hand over
      if (q_push) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_sum_ff <= s1_sum_in;
      s2_sum_ff <= s2_sum_in;
      est_ff    <= est_in;
   end

endmodule

[sv/ntp_avg_queue.sv]
// Short queue of batch averages between front and back end.
// Depends on ntp_pkg.
module ntp_avg_queue
   import ntp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [AVG_W-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [AVG_W-1:0] pop_data,
   output logic             empty
);

   logic [AVG_W-1:0]   slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/ntp_divider.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on ntp_pkg; serves ntp_back through div_req_type / div_resp_type.
module ntp_divider
   import ntp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_req_type  req,
   output div_resp_type resp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   rem_shift;

   assign rem_shift     = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign resp.done     = done_ff;
   assign resp.quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W);
         quo_in  = req.numer;
         rem_in  = '0;
         den_in  = req.denom;
      end else if (busy_ff) begin
         // Shift in one numerator bit, subtract when it fits
         if (rem_shift >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(rem_shift - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

[sv/ntp_back.sv]
// Back end: turns a batch average into resistance, temperature and enable bits.
// Depends on ntp_pkg; uses ntp_divider and drains ntp_avg_queue.
module ntp_back
   import ntp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               q_empty,
   input  logic [AVG_W-1:0]   q_data,
   output logic               q_pop,
   output div_req_type        div_req,
   input  div_resp_type       div_resp,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [CENTI_W-1:0] rsp_temperature_centi,
   output logic               rsp_charge_enable,
   output logic               rsp_boost_enable
);

   back_state_type state_ff, state_in;

   logic [AVG_W-1:0]     avg_ff, avg_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [FULL_W-1:0]    full_ff, full_in;
   logic [DIV_NUM_W-1:0] dnum_ff, dnum_in;
   logic [DIV_DEN_W-1:0] dden_ff, dden_in;
   logic [RES_W-1:0]     r_ff, r_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [CENTI_W-1:0]   temp_ff, temp_in;

   logic               out_valid_ff, out_valid_in;
   logic [CENTI_W-1:0] out_temp_ff, out_temp_in;
   logic               out_charge_ff, out_charge_in;
   logic               out_boost_ff, out_boost_in;

   logic [IDX_W-1:0]      idx_next;
   logic [RES_W-1:0]      hi_ohms, lo_ohms;
   logic [FRAC_NUM_W-1:0] frac_num;
   logic [T_W-1:0]        t_sum;

   assign idx_next  = idx_ff + IDX_W'(1);
   assign hi_ohms   = RES_TABLE[idx_ff];
   assign lo_ohms   = RES_TABLE[idx_next];
   assign frac_num  = FRAC_NUM_W'(hi_ohms - r_ff) * FRAC_NUM_W'(STEP_CENTI);
   assign t_sum     = T_W'(T_MIN_CENTI) + T_W'(idx_ff) * T_W'(STEP_CENTI)
                      + T_W'(div_resp.quotient[STEP_W-1:0]);

   assign div_req.numer = dnum_ff;
   assign div_req.denom = dden_ff;

   assign rsp_empty             = !out_valid_ff;
   assign rsp_temperature_centi = out_temp_ff;
   assign rsp_charge_enable     = out_charge_ff;
   assign rsp_boost_enable      = out_boost_ff;

   always_comb begin
      state_in      = state_ff;
      avg_in        = avg_ff;
      num_in        = num_ff;
      full_in       = full_ff;
      dnum_in       = dnum_ff;
      dden_in       = dden_ff;
      r_in          = r_ff;
      idx_in        = idx_ff;
      temp_in       = temp_ff;
      out_valid_in  = out_valid_ff && !rsp_pop;
      out_temp_in   = out_temp_ff;
      out_charge_in = out_charge_ff;
      out_boost_in  = out_boost_ff;
      q_pop         = 1'b0;
      div_req.start = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               avg_in   = q_data;
               state_in = BK_SCALE;
            end
         end
         BK_SCALE: begin
            num_in   = NUM_W'(cfg.reference_mv) * NUM_W'(avg_in);
            full_in  = {cfg.pull_mv, {ADC_BITS{1'b0}}};
            state_in = BK_RATIO;
         end
         BK_RATIO: begin
            if (CMP_W'(full_ff) <= CMP_W'(num_ff)) begin
               temp_in  = CENTI_W'(T_MAX_CENTI);
               state_in = BK_EMIT;
            end else begin
               dnum_in  = DIV_NUM_W'(cfg.pull_ohms) * DIV_NUM_W'(num_ff);
               dden_in  = DIV_DEN_W'(CMP_W'(full_ff) - CMP_W'(num_ff));
               state_in = BK_START_R;
            end
         end
         BK_START_R: begin
            div_req.start = 1'b1;
            state_in      = BK_WAIT_R;
         end
         BK_WAIT_R: begin
            if (div_resp.done) begin
               state_in = BK_RANGE;
            end
         end
         BK_RANGE: begin
            priority if (div_resp.quotient >= DIV_NUM_W'(RES_TABLE[0])) begin
               temp_in  = CENTI_W'(T_MIN_CENTI);
               state_in = BK_EMIT;
            end else if (div_resp.quotient <= DIV_NUM_W'(RES_TABLE[TABLE_ENTRIES-1])) begin
               temp_in  = CENTI_W'(T_MAX_CENTI);
               state_in = BK_EMIT;
            end else begin
               r_in     = div_resp.quotient[RES_W-1:0];
               idx_in   = '0;
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            // Walk down the table to the segment that holds r
            if (r_ff >= lo_ohms) begin
               state_in = BK_FRAC;
            end else begin
               idx_in = idx_next;
            end
         end
         BK_FRAC: begin
            dnum_in  = DIV_NUM_W'(frac_num);
            dden_in  = DIV_DEN_W'(hi_ohms - lo_ohms);
            state_in = BK_START_F;
         end
         BK_START_F: begin
            div_req.start = 1'b1;
            state_in      = BK_WAIT_F;
         end
         BK_WAIT_F: begin
            if (div_resp.done) begin
               state_in = BK_SUM;
            end
         end
         BK_SUM: begin
            if ($signed(t_sum) > $signed(T_W'(T_MAX_CENTI))) begin
               temp_in = CENTI_W'(T_MAX_CENTI);
            end else begin
               temp_in = t_sum[CENTI_W-1:0];
            end
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            // Hold until the output register frees up
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in  = 1'b1;
               out_temp_in   = temp_ff;
               out_charge_in = ($signed(temp_ff) <= $signed(cfg.charge_limit));
               out_boost_in  = ($signed(temp_ff) <= $signed(cfg.boost_limit));
               state_in      = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      avg_ff        <= avg_in;
      num_ff        <= num_in;
      full_ff       <= full_in;
      dnum_ff       <= dnum_in;
      dden_ff       <= dden_in;
      r_ff          <= r_in;
      idx_ff        <= idx_in;
      temp_ff       <= temp_in;
      out_temp_ff   <= out_temp_in;
      out_charge_ff <= out_charge_in;
      out_boost_ff  <= out_boost_in;
   end

endmodule

[sv/ntc_thermal_power_gate.sv]
// NTC thermal power gate top level: register file, front end, batch queue, back end, divider.
// Samples enter at one beat per cycle while req_full is low; a batch's last beat raises it
// until the average has passed the s1 and s2 registers into the two-entry queue, where a full
// queue holds s2. Back end per batch: a reading at or above the pull voltage maps to the top
// temperature, one past a table end takes one 45-bit division, else two and a table walk.
// Sync reset clears counters, queue and state, loads 3000 mV, 3300 mV, 10000 ohm, 45 C and 50 C.
module ntc_thermal_power_gate
   import ntp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Sample channel
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [ADC_BITS-1:0]    req_sample,
   // Result channel
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [CENTI_W-1:0]     rsp_temperature_centi,
   output logic                   rsp_charge_enable,
   output logic                   rsp_boost_enable,
   // Register write port
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type cfg_ff, cfg_in;

   logic             q_push, q_full, q_pop, q_empty;
   logic [AVG_W-1:0] q_push_data, q_pop_data;

   div_req_type  div_req;
   div_resp_type div_resp;

   // Register writes land directly; unknown indexes drop
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_REFERENCE_MV: cfg_in.reference_mv = csr_write_data[REF_W-1:0];
            CSR_PULL_MV:      cfg_in.pull_mv      = csr_write_data[PULL_MV_W-1:0];
            CSR_PULL_OHMS:    cfg_in.pull_ohms    = csr_write_data[OHMS_W-1:0];
            CSR_CHARGE_LIMIT: cfg_in.charge_limit = csr_write_data[CENTI_W-1:0];
            CSR_BOOST_LIMIT:  cfg_in.boost_limit  = csr_write_data[CENTI_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reference_mv <= RESET_REFERENCE_MV;
         cfg_ff.pull_mv      <= RESET_PULL_MV;
         cfg_ff.pull_ohms    <= RESET_PULL_OHMS;
         cfg_ff.charge_limit <= RESET_CHARGE_LIMIT;
         cfg_ff.boost_limit  <= RESET_BOOST_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accumulate the batch and divide by the batch size
   ntp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_sample (req_sample),
      .q_push     (q_push),
      .q_data     (q_push_data),
      .q_full     (q_full)
   );

   // Decouple batch closing from the slow conversion
   ntp_avg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   // Back: resistance, table walk, interpolation, limit compares, output register
   ntp_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg_ff),
      .q_empty               (q_empty),
      .q_data                (q_pop_data),
      .q_pop                 (q_pop),
      .div_req               (div_req),
      .div_resp              (div_resp),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_charge_enable     (rsp_charge_enable),
      .rsp_boost_enable      (rsp_boost_enable)
   );

   // Shared divider for the resistance and the interpolation fraction
   ntp_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .resp  (div_resp)
   );

endmodule
